/* rtl/core/hbs_pkg.sv */
// Shared types and constants for the heightmap bilinear sampler.
// No dependencies; the interfaces and all modules but hbs_ram import it.
`default_nettype none

package hbs_pkg;

   localparam int QUERY_W  = 20;
   localparam int HEIGHT_W = 16;
   localparam int WIDX_W   = 12;
   localparam int CSR_W    = 13;

   localparam logic [CSR_W-1:0] GRID_WIDTH_RESET   = 13'd64;
   localparam logic [CSR_W-1:0] GRID_ENTRIES_RESET = 13'd4096;

   typedef enum logic [0:0] {
      CSR_GRID_WIDTH   = 1'b0,
      CSR_GRID_ENTRIES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                       mode;
      logic [WIDX_W-1:0]          write_index;
      logic signed [HEIGHT_W-1:0] write_height;
      logic signed [QUERY_W-1:0]  query_x;
      logic signed [QUERY_W-1:0]  query_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height_out;
      logic                       out_of_bounds;
   } rsp_payload_type;

   // per-stage load strobes of the pipeline
   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
      logic load_out;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

/* rtl/core/hbs_if.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on hbs_pkg for the payload structs.
`default_nettype none

interface hbs_req_if;
   import hbs_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hbs_rsp_if;
   import hbs_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/hbs_ram.sv */
// Single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. No package dependency.
`default_nettype none

module hbs_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/hbs_corner.sv */
// Stage 1: floors the query position, forms the base index and derives the
// four corner addresses, bound check and write port. Depends on hbs_pkg.
`default_nettype none

module hbs_corner #(
   parameter int MAX_ENTRIES = 4096,
   parameter int FRAC_BITS   = 8,
   parameter int AW          = 12
) (
   input  logic                                clock,
   input  logic                                load,
   input  hbs_pkg::req_payload_type            req_data,
   input  logic [hbs_pkg::CSR_W-1:0]           grid_width,
   input  logic [hbs_pkg::CSR_W-1:0]           grid_entries,
   output logic                                is_query,
   output logic [3:0][AW-1:0]                  rd_addr,
   output logic                                oob,
   output logic                                wr_ok,
   output logic [AW-1:0]                       wr_addr,
   output logic [hbs_pkg::HEIGHT_W-1:0]        wr_data,
   output logic [FRAC_BITS-1:0]                fx,
   output logic [FRAC_BITS-1:0]                fz
);
   import hbs_pkg::*;

   localparam int IW = QUERY_W - FRAC_BITS;
   localparam int PW = IW + CSR_W + 3;
   localparam logic [16:0] MAX_IDX = 17'(MAX_ENTRIES);

   logic signed [IW-1:0]       x0_c;
   logic signed [IW-1:0]       z0_c;
   logic signed [IW+CSR_W:0]   prod_c;
   logic signed [PW-1:0]       p0_in;
   logic signed [PW-1:0]       p0_ff;
   logic                       mode_ff;
   logic [WIDX_W-1:0]          widx_ff;
   logic [HEIGHT_W-1:0]        wh_ff;
   logic [FRAC_BITS-1:0]       fx_ff;
   logic [FRAC_BITS-1:0]       fz_ff;

   logic [3:0][PW-1:0]         p_c;
   logic [PW-1:0]              w_ext;
   logic [PW-1:0]              ent_ext;
   logic [PW-1:0]              max_ext;
   logic [PW-1:0]              bound_c;
   logic [3:0]                 out_c;
   logic [16:0]                widx_ext;

   // floor of a two's complement fixed-point value is its upper bits
   always_comb begin
      x0_c   = req_data.query_x[QUERY_W-1:FRAC_BITS];
      z0_c   = req_data.query_z[QUERY_W-1:FRAC_BITS];
      prod_c = z0_c * $signed({1'b0, grid_width});
      p0_in  = PW'(prod_c) + PW'(x0_c);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p0_ff   <= p0_in;
         mode_ff <= req_data.mode;
         widx_ff <= req_data.write_index;
         wh_ff   <= req_data.write_height;
         fx_ff   <= req_data.query_x[FRAC_BITS-1:0];
         fz_ff   <= req_data.query_z[FRAC_BITS-1:0];
      end
   end

   always_comb begin
      w_ext   = PW'(grid_width);
      ent_ext = PW'(grid_entries);
      max_ext = PW'(MAX_ENTRIES);
      bound_c = (ent_ext < max_ext) ? ent_ext : max_ext;
      p_c[0]  = p0_ff;
      p_c[1]  = p0_ff + PW'(1);
      p_c[2]  = p0_ff + w_ext;
      p_c[3]  = p0_ff + w_ext + PW'(1);
      for (int k = 0; k < 4; k++) begin
         out_c[k]   = p_c[k][PW-1] || (p_c[k] >= bound_c);
         rd_addr[k] = p_c[k][AW-1:0];
      end
      widx_ext = 17'(widx_ff);
   end

   assign oob      = |out_c;
   assign is_query = mode_ff;
   assign wr_ok    = widx_ext < MAX_IDX;
   assign wr_addr  = widx_ext[AW-1:0];
   assign wr_data  = wh_ff;
   assign fx       = fx_ff;
   assign fz       = fz_ff;

endmodule

`default_nettype wire

/* rtl/core/hbs_lerp.sv */
// Stages 2 to 4: x interpolation of both row pairs, then z interpolation and
// floor into the response register. Depends on hbs_pkg.
`default_nettype none

module hbs_lerp #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  hbs_pkg::pipe_ctrl_type                 ctrl,
   input  logic [FRAC_BITS-1:0]                   fx_s1,
   input  logic [FRAC_BITS-1:0]                   fz_s1,
   input  logic                                   oob_s1,
   input  logic [3:0][hbs_pkg::HEIGHT_W-1:0]      h,
   output hbs_pkg::rsp_payload_type               rsp_data
);
   import hbs_pkg::*;

   localparam int LW = HEIGHT_W + FRAC_BITS;
   localparam int DW = LW + 2;
   localparam int EW = LW + FRAC_BITS + 2;

   logic [FRAC_BITS-1:0]       fx2_ff;
   logic [FRAC_BITS-1:0]       fz2_ff;
   logic                       oob2_ff;

   logic signed [HEIGHT_W-1:0] h0_c, h1_c, h2_c, h3_c;
   logic signed [FRAC_BITS:0]  fx_s;
   logic signed [HEIGHT_W:0]   d01_c, d23_c;
   logic signed [DW-1:0]       m0_c, m1_c;
   logic signed [LW-1:0]       a0_in, a1_in;

   logic signed [LW-1:0]       a0_ff, a1_ff;
   logic [FRAC_BITS-1:0]       fz3_ff;
   logic                       oob3_ff;

   logic signed [FRAC_BITS:0]  fz_s;
   logic signed [LW:0]         dz_c;
   logic signed [EW-1:0]       mz_c;
   logic signed [EW-1:0]       acc_c;
   logic signed [HEIGHT_W-1:0] height_in;

   logic signed [HEIGHT_W-1:0] height_ff;
   logic                       oob_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load2) begin
         fx2_ff  <= fx_s1;
         fz2_ff  <= fz_s1;
         oob2_ff <= oob_s1;
      end
   end

   // a = h_lo*S + fx*(h_hi - h_lo), a weighted mean that fits LW bits
   always_comb begin
      h0_c  = h[0];
      h1_c  = h[1];
      h2_c  = h[2];
      h3_c  = h[3];
      fx_s  = $signed({1'b0, fx2_ff});
      d01_c = (HEIGHT_W+1)'(h1_c) - (HEIGHT_W+1)'(h0_c);
      d23_c = (HEIGHT_W+1)'(h3_c) - (HEIGHT_W+1)'(h2_c);
      m0_c  = fx_s * d01_c;
      m1_c  = fx_s * d23_c;
      a0_in = LW'((DW'(h0_c) <<< FRAC_BITS) + m0_c);
      a1_in = LW'((DW'(h2_c) <<< FRAC_BITS) + m1_c);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load3) begin
         a0_ff   <= a0_in;
         a1_ff   <= a1_in;
         fz3_ff  <= fz2_ff;
         oob3_ff <= oob2_ff;
      end
   end

   // dropping the low 2*FRAC_BITS bits of a two's complement sum floors it
   always_comb begin
      fz_s  = $signed({1'b0, fz3_ff});
      dz_c  = (LW+1)'(a1_ff) - (LW+1)'(a0_ff);
      mz_c  = fz_s * dz_c;
      acc_c = (EW'(a0_ff) <<< FRAC_BITS) + mz_c;
      height_in = oob3_ff ? '0 : acc_c[2*FRAC_BITS+HEIGHT_W-1:2*FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         height_ff <= height_in;
         oob_ff    <= oob3_ff;
      end
   end

   always_comb begin
      rsp_data.height_out    = height_ff;
      rsp_data.out_of_bounds = oob_ff;
   end

endmodule

`default_nettype wire

/* rtl/core/heightmap_bilinear_sampler.sv */
// Heightmap bilinear sampler: request beat -> s1, s2, s3 -> response register.
// Throughput one request beat per cycle unless stalled; each of four corners reads
// its own height RAM copy, all copies written together. Write beats give no response.
// Reset clears the pipeline valids and sets grid_width to 64, grid_entries to 4096;
// height RAM contents stay undefined until written. Depends on hbs_pkg, hbs_if.
`default_nettype none

module heightmap_bilinear_sampler #(
   parameter int MAX_ENTRIES = 4096,
   parameter int FRAC_BITS   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   hbs_req_if.sink                         req_chan,
   hbs_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  hbs_pkg::csr_index_type          csr_index,
   input  logic [hbs_pkg::CSR_W-1:0]       csr_wdata
);
   import hbs_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [CSR_W-1:0]          grid_width_ff, grid_width_in;
   logic [CSR_W-1:0]          grid_entries_ff, grid_entries_in;

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s3_valid_ff, s3_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      adv1, adv2, adv3, adv_out;
   pipe_ctrl_type             ctrl;

   logic                      s1_query;
   logic [3:0][AW-1:0]        rd_addr;
   logic                      s1_oob;
   logic                      wr_ok;
   logic [AW-1:0]             wr_addr;
   logic [HEIGHT_W-1:0]       wr_data;
   logic [FRAC_BITS-1:0]      s1_fx, s1_fz;
   logic                      ram_we;
   logic [3:0][HEIGHT_W-1:0]  rd_data;

   always_comb begin
      grid_width_in   = grid_width_ff;
      grid_entries_in = grid_entries_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:   grid_width_in   = csr_wdata;
            CSR_GRID_ENTRIES: grid_entries_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= GRID_WIDTH_RESET;
         grid_entries_ff <= GRID_ENTRIES_RESET;
      end else begin
         grid_width_ff   <= grid_width_in;
         grid_entries_ff <= grid_entries_in;
      end
   end

   // a stage moves when the next one is empty or moving too
   always_comb begin
      adv_out = !out_valid_ff || rsp_chan.ready;
      adv3    = !s3_valid_ff || adv_out;
      adv2    = !s2_valid_ff || adv3;
      adv1    = !s1_valid_ff || adv2;
      ctrl.load1    = adv1;
      ctrl.load2    = adv2;
      ctrl.load3    = adv3;
      ctrl.load_out = adv_out;
      s1_valid_in  = adv1 ? req_chan.valid : s1_valid_ff;
      s2_valid_in  = adv2 ? (s1_valid_ff && s1_query) : s2_valid_ff;
      s3_valid_in  = adv3 ? s2_valid_ff : s3_valid_ff;
      out_valid_in = adv_out ? s3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_chan.ready = adv1;

   hbs_corner #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .FRAC_BITS   (FRAC_BITS),
      .AW          (AW)
   ) u_corner (
      .clock        (clock),
      .load         (ctrl.load1),
      .req_data     (req_chan.payload),
      .grid_width   (grid_width_ff),
      .grid_entries (grid_entries_ff),
      .is_query     (s1_query),
      .rd_addr      (rd_addr),
      .oob          (s1_oob),
      .wr_ok        (wr_ok),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .fx           (s1_fx),
      .fz           (s1_fz)
   );

   // writes land in the same stage that queries read, so beat order holds
   assign ram_we = s1_valid_ff && !s1_query && wr_ok && adv2;

   for (genvar k = 0; k < 4; k++) begin : g_bank
      hbs_ram #(
         .DEPTH (MAX_ENTRIES),
         .AW    (AW),
         .DW    (HEIGHT_W)
      ) u_ram (
         .clock (clock),
         .we    (ram_we),
         .waddr (wr_addr),
         .wdata (wr_data),
         .re    (adv2),
         .raddr (rd_addr[k]),
         .rdata (rd_data[k])
      );
   end

   hbs_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .clock    (clock),
      .ctrl     (ctrl),
      .fx_s1    (s1_fx),
      .fz_s1    (s1_fz),
      .oob_s1   (s1_oob),
      .h        (rd_data),
      .rsp_data (rsp_chan.payload)
   );

   assign rsp_chan.valid = out_valid_ff;

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && out_valid_ff && !rsp_chan.ready)
      |-> !req_chan.ready)
      else $error("request taken while pipeline full and stalled");

   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.out_of_bounds)
      |-> (rsp_chan.payload.height_out == '0))
      else $error("out-of-bounds response with nonzero height");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s3_valid_ff))
      else $error("response appeared without a query in the last stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* dv/heightmap_bilinear_sampler_tb.sv */
// Self-checking testbench for heightmap_bilinear_sampler: height loads and bilinear queries.
// A directed table comes first, then random beats over several grid settings.
// Depends on hbs_pkg, hbs_if and the heightmap_bilinear_sampler RTL.

module heightmap_bilinear_sampler_tb;
   import hbs_pkg::*;

   localparam int    MAX_ENTRIES = 4096;
   localparam int    FRAC_BITS   = 8;
   localparam longint SCALE      = longint'(1) << FRAC_BITS;
   localparam logic  MODE_WRITE  = 1'b0;
   localparam logic  MODE_QUERY  = 1'b1;
   localparam int    NUM_PHASES  = 8;
   localparam int    PHASE_BEATS = 64;

   typedef struct {
      req_payload_type beat;
      bit              typed;
      rsp_payload_type answer;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   hbs_req_if req_bus();
   hbs_rsp_if rsp_bus();

   heightmap_bilinear_sampler #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .FRAC_BITS   (FRAC_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block state
   logic signed [HEIGHT_W-1:0] grid_heights [MAX_ENTRIES];
   bit                         entry_loaded [MAX_ENTRIES];
   logic [CSR_W-1:0]           grid_width_cfg;
   logic [CSR_W-1:0]           grid_entries_cfg;

   rsp_payload_type pending_samples[$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;
   bit              long_hold_req  = 1'b0;
   int              hold_left      = 0;

   int unsigned phase_width   [NUM_PHASES] = '{0, 1, 4096, 64, 7, 200, 33, 64};
   int unsigned phase_entries [NUM_PHASES] = '{4096, 8191, 4096, 0, 100, 3000, 4096, 4096};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("heightmap_bilinear_sampler_tb: FAIL");
      $finish;
   end

   // bilinear height at (qx, qz) under the current grid settings; corners returned too
   function automatic rsp_payload_type interpolate_height(
      input  logic signed [QUERY_W-1:0] qx,
      input  logic signed [QUERY_W-1:0] qz,
      output int                        corner[4]);
      longint          x0, z0, fx, fz, w, bnd, a0, a1, acc;
      longint          p[4];
      longint          h[4];
      rsp_payload_type r;
      x0  = longint'(qx) >>> FRAC_BITS;
      z0  = longint'(qz) >>> FRAC_BITS;
      fx  = longint'(qx) - x0 * SCALE;
      fz  = longint'(qz) - z0 * SCALE;
      w   = longint'(grid_width_cfg);
      bnd = (grid_entries_cfg > MAX_ENTRIES) ? MAX_ENTRIES : longint'(grid_entries_cfg);
      p[0] = z0 * w + x0;
      p[1] = p[0] + 1;
      p[2] = p[0] + w;
      p[3] = p[0] + w + 1;
      r = '0;
      r.out_of_bounds = 1'b1;
      foreach (p[i]) corner[i] = int'(p[i]);
      foreach (p[i]) if (p[i] < 0 || p[i] >= bnd) return r;
      r.out_of_bounds = 1'b0;
      foreach (p[i]) h[i] = longint'(grid_heights[p[i]]);
      a0  = h[0] * SCALE + fx * (h[1] - h[0]);
      a1  = h[2] * SCALE + fx * (h[3] - h[2]);
      acc = a0 * SCALE + fz * (a1 - a0);
      r.height_out = HEIGHT_W'(acc >>> (2 * FRAC_BITS));
      return r;
   endfunction

   function automatic stim_row_type stim(logic mode, logic [WIDX_W-1:0] idx,
                                         logic [HEIGHT_W-1:0] hgt, logic [QUERY_W-1:0] qx,
                                         logic [QUERY_W-1:0] qz, bit typed,
                                         logic [HEIGHT_W-1:0] hexp, logic oob);
      stim_row_type s;
      s.beat.mode                 = mode;
      s.beat.write_index          = idx;
      s.beat.write_height         = hgt;
      s.beat.query_x              = qx;
      s.beat.query_z              = qz;
      s.typed                     = typed;
      s.answer.height_out         = hexp;
      s.answer.out_of_bounds      = oob;
      return s;
   endfunction

   // mostly queries aimed inside the grid; the rest are raw positions and loads
   function automatic req_payload_type random_item();
      req_payload_type b;
      int w, bnd, p0, x0, z0, z0max;
      b.write_index  = WIDX_W'($urandom);
      b.write_height = HEIGHT_W'($urandom);
      b.query_x      = QUERY_W'($urandom);
      b.query_z      = QUERY_W'($urandom);
      b.mode         = ($urandom_range(0, 99) < 20) ? MODE_WRITE : MODE_QUERY;
      w   = int'(grid_width_cfg);
      bnd = (grid_entries_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(grid_entries_cfg);
      if (b.mode == MODE_QUERY && $urandom_range(0, 99) < 75) begin
         if (w == 0 && bnd >= 2) begin
            // zero stride: every row maps onto the same indices
            x0 = $urandom_range(0, (bnd - 2 > 2047) ? 2047 : bnd - 2);
            b.query_x[QUERY_W-1:FRAC_BITS] = x0[11:0];
         end else if (w > 0 && bnd - w - 2 >= 0) begin
            p0    = $urandom_range(0, bnd - w - 2);
            z0max = (p0 / w > 2047) ? 2047 : p0 / w;
            z0    = $urandom_range(0, z0max);
            x0    = p0 - z0 * w;
            if (x0 > 2047) begin
               z0 = z0max;
               x0 = p0 - z0 * w;
            end
            b.query_x[QUERY_W-1:FRAC_BITS] = x0[11:0];
            b.query_z[QUERY_W-1:FRAC_BITS] = z0[11:0];
         end
      end
      return b;
   endfunction

   task automatic drive_beat(req_payload_type beat);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= beat;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // queries first get loads for any corner that was never written
   task automatic issue_item(req_payload_type beat, bit typed, rsp_payload_type answer);
      rsp_payload_type guess;
      req_payload_type fill;
      int              corner[4];
      if (beat.mode == MODE_QUERY) begin
         guess = interpolate_height(beat.query_x, beat.query_z, corner);
         if (!guess.out_of_bounds) begin
            foreach (corner[i]) begin
               if (!entry_loaded[corner[i]]) begin
                  fill.mode         = MODE_WRITE;
                  fill.write_index  = WIDX_W'(corner[i]);
                  fill.write_height = HEIGHT_W'($urandom);
                  fill.query_x      = QUERY_W'($urandom);
                  fill.query_z      = QUERY_W'($urandom);
                  grid_heights[fill.write_index] = fill.write_height;
                  entry_loaded[fill.write_index] = 1'b1;
                  drive_beat(fill);
               end
            end
         end
         guess = interpolate_height(beat.query_x, beat.query_z, corner);
         pending_samples.insert(pending_samples.size(), typed ? answer : guess);
      end else begin
         grid_heights[beat.write_index] = beat.write_height;
         entry_loaded[beat.write_index] = 1'b1;
      end
      drive_beat(beat);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_GRID_WIDTH) grid_width_cfg = value;
      else grid_entries_cfg = value;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_samples.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no result beat, actual height=%0d oob=%0b", $time,
                     rsp_bus.payload.height_out, rsp_bus.payload.out_of_bounds);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_bus.payload.height_out !== want.height_out) begin
               mismatch_count++;
               $display("%0t: height_out expected %0d actual %0d", $time,
                        want.height_out, rsp_bus.payload.height_out);
            end
            if (rsp_bus.payload.out_of_bounds !== want.out_of_bounds) begin
               mismatch_count++;
               $display("%0t: out_of_bounds expected %0b actual %0b", $time,
                        want.out_of_bounds, rsp_bus.payload.out_of_bounds);
            end
         end
      end
   end

   // result side readiness, with one long hold-off
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left     = 120;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      stim_row_type directed_rows[];
      int           phase, n;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.payload  = '0;
      rsp_bus.ready    = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_GRID_WIDTH;
      csr_wdata        = '0;
      grid_width_cfg   = GRID_WIDTH_RESET;
      grid_entries_cfg = GRID_ENTRIES_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset grid: stride 64, 4096 entries
      directed_rows = '{
         stim(MODE_WRITE, 12'd0,    16'h7FFF, 20'h0,     20'h0,     1'b0, 16'h0,    1'b0),
         stim(MODE_WRITE, 12'd1,    16'h8000, 20'h0,     20'h0,     1'b0, 16'h0,    1'b0),
         stim(MODE_WRITE, 12'd64,   16'h0000, 20'h0,     20'h0,     1'b0, 16'h0,    1'b0),
         stim(MODE_WRITE, 12'd65,   16'h0001, 20'h0,     20'h0,     1'b0, 16'h0,    1'b0),
         stim(MODE_QUERY, 12'd0,    16'h0,    20'h0,     20'h0,     1'b1, 16'h7FFF, 1'b0),
         // largest fraction on both axes
         stim(MODE_QUERY, 12'd0,    16'h0,    20'h000FF, 20'h000FF, 1'b0, 16'h0,    1'b0),
         // just left of the grid and just above it
         stim(MODE_QUERY, 12'd0,    16'h0,    20'hFFFFF, 20'h0,     1'b1, 16'h0,    1'b1),
         stim(MODE_QUERY, 12'd0,    16'h0,    20'h0,     20'hFFF00, 1'b1, 16'h0,    1'b1),
         stim(MODE_QUERY, 12'd0,    16'h0,    20'h7FFFF, 20'h0,     1'b0, 16'h0,    1'b0),
         stim(MODE_QUERY, 12'd0,    16'h0,    20'h80000, 20'h80000, 1'b1, 16'h0,    1'b1),
         stim(MODE_QUERY, 12'd0,    16'h0,    20'h0,     20'h7FFFF, 1'b1, 16'h0,    1'b1),
         stim(MODE_WRITE, 12'd4095, 16'h1234, 20'hABCDE, 20'h54321, 1'b0, 16'h0,    1'b0),
         // last cell of the grid, reads entry 4095
         stim(MODE_QUERY, 12'd0,    16'h0,    20'd16000, 20'd16000, 1'b0, 16'h0,    1'b0),
         // end of a row wraps into the next row
         stim(MODE_QUERY, 12'd0,    16'h0,    20'd16145, 20'd1480,  1'b0, 16'h0,    1'b0),
         // bottom row: lower corners fall past the end
         stim(MODE_QUERY, 12'd0,    16'h0,    20'h0,     20'd16128, 1'b1, 16'h0,    1'b1),
         stim(MODE_QUERY, 12'd0,    16'h0,    20'd256,   20'h0,     1'b1, 16'h8000, 1'b0),
         stim(MODE_WRITE, 12'hAAA,  16'h5555, 20'hFFFFF, 20'h0,     1'b0, 16'h0,    1'b0),
         stim(MODE_WRITE, 12'h555,  16'hAAAA, 20'h0,     20'hFFFFF, 1'b0, 16'h0,    1'b0),
         stim(MODE_QUERY, 12'd0,    16'h0,    20'd21888, 20'd5461,  1'b0, 16'h0,    1'b0)
      };

      send_idle_pct = 31;
      recv_idle_pct = 65;
      foreach (directed_rows[i])
         issue_item(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].answer);
      drain_results();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 31;
         end
         if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_GRID_WIDTH,   CSR_W'(phase_width[phase]));
         write_csr(CSR_GRID_ENTRIES, CSR_W'(phase_entries[phase]));
         for (n = 0; n < PHASE_BEATS; n++) begin
            if (phase == 1 && n == 40) long_hold_req = 1'b1;
            if (phase == 4 && n == 60) drain_results();
            issue_item(random_item(), 1'b0, '0);
         end
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("heightmap_bilinear_sampler_tb: PASS");
      end else begin
         $display("heightmap_bilinear_sampler_tb: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/hbs_pkg.sv
rtl/core/hbs_if.sv
rtl/core/hbs_ram.sv
rtl/core/hbs_corner.sv
rtl/core/hbs_lerp.sv
rtl/core/heightmap_bilinear_sampler.sv
dv/heightmap_bilinear_sampler_tb.sv
